### sv/tftp_wr_pkg.sv
// ----------------------------------------------------------------------------
// TFTP write receiver package
// Shared codes and sizes for the receiver and its checker.
// ----------------------------------------------------------------------------
package tftp_wr_pkg;

  localparam int unsigned BlockBytes = 512;

  localparam logic [15:0] TftpData        = 16'd3;
  localparam logic [15:0] TftpAck         = 16'd4;
  localparam logic [15:0] TftpErrIllegalOp = 16'd4;
  localparam logic [3:0]  RetryLimitReset = 4'd10;
  localparam logic [3:0]  RetryCountMax   = 4'd15;

  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_PKT   = 2'd1,
    FUNC_TICK  = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_ACK   = 2'd1,
    ACT_ERROR = 2'd2
  } action_e;

  // Status codes reported on the result
  localparam logic [2:0] StIdle      = 3'd0;
  localparam logic [2:0] StReceiving = 3'd1;
  localparam logic [2:0] StComplete  = 3'd2;
  localparam logic [2:0] StTimedOut  = 3'd3;
  localparam logic [2:0] StProtoErr  = 3'd4;

endpackage

### sv/tftp_write_receiver.sv
// ----------------------------------------------------------------------------
// TFTP write receiver
// Stop-and-wait receiving side of a TFTP write: one event in, one reply out.
// ----------------------------------------------------------------------------
// Path: an accepted input beat goes through the input register, then the
//   result register, to become its result beat.
// Throughput: one event per cycle while out_stall_i does not hold the result
//   beat; the transfer state updates as each event moves from the input register into the result register.
// Reset: phase idle, expected block and retry count zero, retry_limit 10,
//   both pipeline registers empty.
module tftp_write_receiver
  import tftp_wr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // event channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [15:0] opcode_i,
  input  logic [15:0] block_num_i,
  input  logic [9:0]  payload_len_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  action_o,
  output logic [15:0] tx_value_o,
  output logic        write_payload_o,
  output logic [2:0]  status_o,
  // retry_limit register write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_data_i
);

  typedef enum logic [2:0] {
    PH_IDLE      = StIdle,
    PH_RECEIVING = StReceiving,
    PH_COMPLETE  = StComplete,
    PH_TIMEDOUT  = StTimedOut,
    PH_PROTO_ERR = StProtoErr
  } phase_e;

  // Input register
  logic        in_vld_q;
  logic [1:0]  func_q;
  logic [15:0] opcode_q;
  logic [15:0] blk_q;
  logic [9:0]  plen_q;

  // Result register
  logic        out_vld_q;
  logic [1:0]  action_q, action_d;
  logic [15:0] txv_q, txv_d;
  logic        wr_q, wr_d;
  logic [2:0]  status_q;

  // Transfer state
  phase_e      phase_q, phase_d;
  logic [15:0] exp_blk_q, exp_blk_d;
  logic [3:0]  retry_q, retry_d;
  logic [3:0]  retry_inc;
  logic [3:0]  limit_q;

  logic adv;   // result register free to load this cycle
  logic proc;  // an event is evaluated and commits state this cycle

  assign adv        = !out_vld_q || !out_stall_i;
  assign proc       = in_vld_q && adv;
  // Hold the input beat only while a loaded input register cannot drain
  assign in_stall_o = in_vld_q && !adv;
  assign cfg_ready_o = 1'b1;

  assign retry_inc = (retry_q < RetryCountMax) ? retry_q + 4'd1 : retry_q;

  // Evaluate one event against the current transfer state
  always_comb begin
    action_d  = ACT_NONE;
    txv_d     = '0;
    wr_d      = 1'b0;
    phase_d   = phase_q;
    exp_blk_d = exp_blk_q;
    retry_d   = retry_q;
    case (func_q)
      FUNC_START: begin
        // Start always restarts, whatever the phase
        action_d  = ACT_ACK;
        exp_blk_d = 16'd1;
        retry_d   = '0;
        phase_d   = PH_RECEIVING;
      end
      FUNC_PKT: begin
        if (phase_q == PH_RECEIVING) begin
          retry_d = '0;
          if (opcode_q != TftpData) begin
            action_d = ACT_ERROR;
            txv_d    = TftpErrIllegalOp;
            phase_d  = PH_PROTO_ERR;
          end else if (blk_q == exp_blk_q) begin
            wr_d     = 1'b1;
            action_d = ACT_ACK;
            txv_d    = exp_blk_q;
            // Short block ends the transfer; a full one moves on
            if (plen_q < 10'(BlockBytes)) begin
              phase_d = PH_COMPLETE;
            end else begin
              exp_blk_d = exp_blk_q + 16'd1;
            end
          end else if (blk_q < exp_blk_q) begin
            // Duplicate of an old block: re-ACK it
            action_d = ACT_ACK;
            txv_d    = blk_q;
          end else begin
            action_d = ACT_ERROR;
            txv_d    = TftpErrIllegalOp;
            phase_d  = PH_PROTO_ERR;
          end
        end
      end
      FUNC_TICK: begin
        if (phase_q == PH_RECEIVING) begin
          // Resend the last ACK, give up once the limit is reached
          action_d = ACT_ACK;
          txv_d    = exp_blk_q - 16'd1;
          retry_d  = retry_inc;
          if (retry_inc >= limit_q) begin
            phase_d = PH_TIMEDOUT;
          end
        end
      end
      default: begin
        // Unused event code: ignore
      end
    endcase
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      phase_q   <= PH_IDLE;
      exp_blk_q <= '0;
      retry_q   <= '0;
      limit_q   <= RetryLimitReset;
    end else begin
      if (!in_stall_o) begin
        in_vld_q <= in_valid_i;
      end
      if (adv) begin
        out_vld_q <= in_vld_q;
      end
      if (proc) begin
        phase_q   <= phase_d;
        exp_blk_q <= exp_blk_d;
        retry_q   <= retry_d;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      func_q   <= func_i;
      opcode_q <= opcode_i;
      blk_q    <= block_num_i;
      plen_q   <= payload_len_i;
    end
    if (proc) begin
      action_q <= action_d;
      txv_q    <= txv_d;
      wr_q     <= wr_d;
      status_q <= phase_d;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign action_o        = action_q;
  assign tx_value_o      = txv_q;
  assign write_payload_o = wr_q;
  assign status_o        = status_q;

endmodule

### sv/tftp_wr_checker.sv
// ----------------------------------------------------------------------------
// TFTP write receiver checker
// Port-level properties of the receiver results, bound into every tftp_write_receiver instance.
// ----------------------------------------------------------------------------
module tftp_wr_checker
  import tftp_wr_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  action_o,
  input logic [15:0] tx_value_o,
  input logic        write_payload_o,
  input logic [2:0]  status_o
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(action_o)
      && $stable(tx_value_o) && $stable(write_payload_o) && $stable(status_o))
    else $error("stalled result beat changed");

  a_none_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && action_o == ACT_NONE |-> tx_value_o == '0 && !write_payload_o)
    else $error("silent result carries a value or a write");

  a_write_acked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && write_payload_o |-> action_o == ACT_ACK
      && (status_o == StReceiving || status_o == StComplete))
    else $error("payload write without ACK or in wrong phase");

  a_error_aborts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && action_o == ACT_ERROR |-> tx_value_o == TftpErrIllegalOp
      && status_o == StProtoErr)
    else $error("error reply without protocol-error abort");

endmodule

bind tftp_write_receiver tftp_wr_checker u_tftp_wr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .action_o        (action_o),
  .tx_value_o      (tx_value_o),
  .write_payload_o (write_payload_o),
  .status_o        (status_o)
);

### bench/testbench.sv
// ----------------------------------------------------------------------------
// TFTP write receiver testbench
// Drives start, packet and timeout events into the receiver under random
// gaps and result stalls, and checks every reply beat against a transfer
// tracker kept here. Runs a short table of hand-picked events, then random
// transfers under several retry limits.
// ----------------------------------------------------------------------------
module testbench;
  import tftp_wr_pkg::*;

  // The func field is two bits wide; the top code is not a defined event.
  localparam logic [1:0] FuncUnknown = 2'd3;
  localparam int unsigned IdlePct    = 34;
  localparam int unsigned HangLimit  = 1000;
  localparam int unsigned DrainTail  = 4;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] opcode;
    logic [15:0] blk;
    logic [9:0]  plen;
  } rx_event_t;

  typedef struct packed {
    action_e     action;
    logic [15:0] txv;
    logic        wr;
    logic [2:0]  status;
  } reply_t;

  // One row of the directed table: an optional retry_limit write ahead of
  // the event, and a hand-typed reply where it is obvious.
  typedef struct packed {
    rx_event_t ev;
    logic      set_limit;
    logic [3:0] limit;
    logic      fixed;
    reply_t    reply;
  } dir_row_t;

  localparam reply_t NoReply = '{ACT_NONE, 16'd0, 1'b0, StIdle};
  localparam reply_t IllegalOp = '{ACT_ERROR, TftpErrIllegalOp, 1'b0, StProtoErr};
  localparam reply_t AckZero = '{ACT_ACK, 16'd0, 1'b0, StReceiving};

  // Rows with fixed = 0 take their reply from the tracker; NoReply there is
  // only a filler.
  localparam dir_row_t DirTab [25] = '{
    // packet, tick and unknown event while idle: all dropped
    '{'{FUNC_PKT,    TftpData,    16'd1,     10'd512},  1'b0, 4'd0,  1'b1, NoReply},
    '{'{FUNC_TICK,   16'd0,       16'd0,     10'd0},    1'b0, 4'd0,  1'b1, NoReply},
    '{'{FuncUnknown, 16'hFFFF,    16'hFFFF,  10'h3FF},  1'b0, 4'd0,  1'b1, NoReply},
    '{'{FUNC_START,  16'd0,       16'd0,     10'd0},    1'b0, 4'd0,  1'b1, AckZero},
    '{'{FUNC_PKT,    TftpData,    16'd1,     10'd512},  1'b0, 4'd0,  1'b1,
      '{ACT_ACK, 16'd1, 1'b1, StReceiving}},
    // length above the block size counts as a full block
    '{'{FUNC_PKT,    TftpData,    16'd2,     10'h3FF},  1'b0, 4'd0,  1'b0, NoReply},
    // older blocks get a repeat ACK
    '{'{FUNC_PKT,    TftpData,    16'd1,     10'd0},    1'b0, 4'd0,  1'b0, NoReply},
    '{'{FUNC_PKT,    TftpData,    16'd0,     10'd512},  1'b0, 4'd0,  1'b0, NoReply},
    '{'{FUNC_TICK,   16'd0,       16'd0,     10'd0},    1'b0, 4'd0,  1'b0, NoReply},
    '{'{FUNC_TICK,   16'hFFFF,    16'hFFFF,  10'h3FF},  1'b0, 4'd0,  1'b0, NoReply},
    '{'{FuncUnknown, TftpData,    16'd3,     10'd512},  1'b0, 4'd0,  1'b0, NoReply},
    // lower the limit below the running count, then tick
    '{'{FUNC_TICK,   16'd0,       16'd0,     10'd0},    1'b1, 4'd1,  1'b0, NoReply},
    '{'{FUNC_PKT,    TftpData,    16'd3,     10'd512},  1'b0, 4'd0,  1'b0, NoReply},
    '{'{FUNC_START,  16'hFFFF,    16'hFFFF,  10'h3FF},  1'b0, 4'd0,  1'b1, AckZero},
    // non-DATA opcode aborts
    '{'{FUNC_PKT,    16'hFFFF,    16'd1,     10'd512},  1'b0, 4'd0,  1'b1, IllegalOp},
    '{'{FUNC_TICK,   16'd0,       16'd0,     10'd0},    1'b0, 4'd0,  1'b0, NoReply},
    '{'{FUNC_START,  16'd0,       16'd0,     10'd0},    1'b0, 4'd0,  1'b1, AckZero},
    // block from the future aborts
    '{'{FUNC_PKT,    TftpData,    16'hFFFF,  10'd0},    1'b0, 4'd0,  1'b1, IllegalOp},
    // limit zero: the first tick resends and gives up
    '{'{FUNC_START,  16'd0,       16'd0,     10'd0},    1'b1, 4'd0,  1'b1, AckZero},
    '{'{FUNC_TICK,   16'd0,       16'd0,     10'd0},    1'b0, 4'd0,  1'b1,
      '{ACT_ACK, 16'd0, 1'b0, StTimedOut}},
    '{'{FUNC_START,  16'd0,       16'd0,     10'd0},    1'b1, 4'hF,  1'b1, AckZero},
    // short payload ends the transfer
    '{'{FUNC_PKT,    TftpData,    16'd1,     10'd0},    1'b0, 4'd0,  1'b1,
      '{ACT_ACK, 16'd1, 1'b1, StComplete}},
    '{'{FUNC_PKT,    16'd0,       16'd0,     10'd0},    1'b0, 4'd0,  1'b0, NoReply},
    '{'{FUNC_START,  16'd0,       16'd0,     10'd0},    1'b0, 4'd0,  1'b1, AckZero},
    '{'{FUNC_PKT,    16'd0,       16'd0,     10'd0},    1'b0, 4'd0,  1'b1, IllegalOp}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  func_i;
  logic [15:0] opcode_i;
  logic [15:0] block_num_i;
  logic [9:0]  payload_len_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  action_o;
  logic [15:0] tx_value_o;
  logic        write_payload_o;
  logic [2:0]  status_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [3:0]  cfg_data_i;

  // Transfer tracker: our own view of the receiver's state.
  logic [15:0] want_blk;
  logic [3:0]  retries;
  logic [2:0]  xfer_phase;
  logic [3:0]  retry_limit;
  int unsigned tick_run;

  reply_t      reply_q[$];
  int unsigned mismatches;
  int unsigned random_items;
  bit          gaps_on;

  tftp_write_receiver dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .func_i          (func_i),
    .opcode_i        (opcode_i),
    .block_num_i     (block_num_i),
    .payload_len_i   (payload_len_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .action_o        (action_o),
    .tx_value_o      (tx_value_o),
    .write_payload_o (write_payload_o),
    .status_o        (status_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Advance the tracker by one accepted event and return the reply it owes.
  function automatic reply_t track_event(rx_event_t ev);
    reply_t     r;
    logic [9:0] len;
    r = NoReply;
    len = (ev.plen > BlockBytes) ? 10'(BlockBytes) : ev.plen;
    if (ev.func == FUNC_START) begin
      r.action = ACT_ACK;
      want_blk = 16'd1;
      retries = 4'd0;
      xfer_phase = StReceiving;
    end else if (xfer_phase == StReceiving && ev.func == FUNC_PKT) begin
      retries = 4'd0;
      if (ev.opcode != TftpData || ev.blk > want_blk) begin
        r.action = ACT_ERROR;
        r.txv = TftpErrIllegalOp;
        xfer_phase = StProtoErr;
      end else if (ev.blk == want_blk) begin
        r.action = ACT_ACK;
        r.txv = want_blk;
        r.wr = 1'b1;
        if (len < BlockBytes) xfer_phase = StComplete;
        else want_blk = want_blk + 16'd1;
      end else begin
        // duplicate of a block already taken
        r.action = ACT_ACK;
        r.txv = ev.blk;
      end
    end else if (xfer_phase == StReceiving && ev.func == FUNC_TICK) begin
      r.action = ACT_ACK;
      r.txv = want_blk - 16'd1;
      if (retries != RetryCountMax) retries = retries + 4'd1;
      if (retries >= retry_limit) xfer_phase = StTimedOut;
    end
    r.status = xfer_phase;
    return r;
  endfunction

  // Pick the next random event. Mostly a well-formed transfer: in-order
  // DATA blocks with random lengths, some ticks, bursts of ticks long enough
  // to hit the retry limit, and a sprinkling of duplicates, bad opcodes,
  // future blocks, restarts and plain noise.
  function automatic rx_event_t pick_event();
    rx_event_t   ev;
    int unsigned r;
    ev.func = 2'($urandom_range(0, 3));
    ev.opcode = 16'($urandom);
    ev.blk = 16'($urandom);
    ev.plen = 10'($urandom);
    r = $urandom_range(0, 99);
    if (xfer_phase != StReceiving) begin
      tick_run = 0;
      if (r < 65) ev.func = FUNC_START;
    end else if (tick_run > 0) begin
      tick_run--;
      ev.func = FUNC_TICK;
    end else if (r < 3) begin
      tick_run = $urandom_range(1, 16);
      ev.func = FUNC_TICK;
    end else if (r < 58) begin
      ev.func = FUNC_PKT;
      ev.opcode = TftpData;
      ev.blk = want_blk;
      ev.plen = ($urandom_range(0, 99) < 85) ? 10'($urandom_range(512, 1023))
                                             : 10'($urandom_range(0, 511));
    end else if (r < 70) begin
      ev.func = FUNC_TICK;
    end else if (r < 78) begin
      ev.func = FUNC_PKT;
      ev.opcode = TftpData;
      ev.blk = (want_blk == 16'd0) ? want_blk
                                   : 16'($urandom_range(0, int'(want_blk) - 1));
    end else if (r < 84) begin
      ev.func = FUNC_PKT;
      if (ev.opcode == TftpData) ev.opcode = ~TftpData;
    end else if (r < 89) begin
      ev.func = FUNC_PKT;
      ev.opcode = TftpData;
      ev.blk = (want_blk == 16'hFFFF) ? want_blk
                                      : 16'($urandom_range(int'(want_blk) + 1, 65535));
    end else if (r < 93) begin
      ev.func = FUNC_START;
    end else if (r < 96) begin
      ev.func = FuncUnknown;
    end
    return ev;
  endfunction

  // Present one event beat and hold it until accepted; queue its reply.
  task automatic offer(input rx_event_t ev, input logic fixed, input reply_t reply);
    reply_t r;
    while (gaps_on && $urandom_range(0, 99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    func_i        <= ev.func;
    opcode_i      <= ev.opcode;
    block_num_i   <= ev.blk;
    payload_len_i <= ev.plen;
    do @(posedge clk_i); while (in_stall_o);
    r = track_event(ev);
    reply_q.push_back(fixed ? reply : r);
  endtask

  // Drain every outstanding reply, then write retry_limit.
  task automatic set_retry_limit(input logic [3:0] lim);
    in_valid_i <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= lim;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    retry_limit = lim;
  endtask

  task automatic random_phase(input int unsigned n_items, input logic [3:0] lim);
    set_retry_limit(lim);
    repeat (n_items) begin
      // hold the sender busy without gaps over one stretch of items
      gaps_on = !(random_items >= 400 && random_items < 550);
      offer(pick_event(), 1'b0, NoReply);
      random_items++;
    end
    gaps_on = 1'b1;
  endtask

  task automatic cmp(input string what, input int unsigned want, input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  // Result side: random stalls, one long hold-off that backs the receiver
  // up into its input, and a window with no stalls at all.
  initial begin
    int unsigned cyc;
    cyc = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc == 800) begin
        out_stall_i <= 1'b1;
        repeat (300) @(posedge clk_i);
        cyc += 300;
      end
      if (cyc >= 1400 && cyc < 2000) out_stall_i <= 1'b0;
      else out_stall_i <= ($urandom_range(0, 99) < IdlePct);
    end
  end

  // Check each result beat against the oldest queued reply.
  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (reply_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result beat, expected none, actual action %0d tx %0d",
                 $time, action_o, tx_value_o);
      end else begin
        want = reply_q.pop_front();
        cmp("action", want.action, action_o);
        cmp("tx_value", want.txv, tx_value_o);
        cmp("write_payload", want.wr, write_payload_o);
        cmp("status", want.status, status_o);
      end
    end
  end

  // Watchdog: end the run if no beat moves on any channel for too long.
  always @(posedge clk_i) begin
    int unsigned quiet;
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= HangLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    func_i        <= FUNC_START;
    opcode_i      <= 16'd0;
    block_num_i   <= 16'd0;
    payload_len_i <= 10'd0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= 4'd0;
    want_blk      = 16'd0;
    retries       = 4'd0;
    xfer_phase    = StIdle;
    retry_limit   = RetryLimitReset;
    tick_run      = 0;
    mismatches    = 0;
    random_items  = 0;
    gaps_on       = 1'b1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (DirTab[i]) begin
      if (DirTab[i].set_limit) set_retry_limit(DirTab[i].limit);
      offer(DirTab[i].ev, DirTab[i].fixed, DirTab[i].reply);
    end

    random_phase(240, 4'hF);
    random_phase(240, 4'd0);
    random_phase(230, 4'd1);
    random_phase(240, 4'($urandom_range(2, 14)));

    // Drop valid, wait out every reply, then a short tail for stray beats.
    in_valid_i <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (DrainTail) @(posedge clk_i);
    if (mismatches == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### filelist.f
sv/tftp_wr_pkg.sv
sv/tftp_write_receiver.sv
sv/tftp_wr_checker.sv
bench/testbench.sv
